FILE: hdl/psfgr_pkg.sv
// psfgr_pkg: shared types, constants and helpers for the psf1 glyph renderer
// used by psfgr_ctrl, psfgr_dpath and psf1_glyph_renderer_top; no dependencies
package psfgr_pkg;

   localparam int GLYPH_COUNT    = 512;
   localparam int MAX_GLYPH_ROWS = 32;
   localparam int COORD_BITS     = 12;
   localparam int CODE_BITS      = 16;

   localparam int GLYPH_BITS = $clog2(GLYPH_COUNT);
   localparam int ROW_BITS   = $clog2(MAX_GLYPH_ROWS);
   localparam int CNT_BITS   = GLYPH_BITS + 1;
   localparam int STORE_BITS = GLYPH_BITS + ROW_BITS;
   localparam int MAP_DEPTH  = 1 << CODE_BITS;
   localparam int STORE_DEPTH = GLYPH_COUNT * MAX_GLYPH_ROWS;

   localparam logic [15:0] TABLE_DELIM = 16'hffff;
   localparam logic [9:0]  GLYPH_LIMIT = 10'h1ff;

   // input operation codes
   localparam logic [1:0] OP_TABLE = 2'd0;
   localparam logic [1:0] OP_LOAD  = 2'd1;
   localparam logic [1:0] OP_DRAW  = 2'd2;

   // result status codes
   localparam logic [1:0] RSP_PIXEL       = 2'd0;
   localparam logic [1:0] RSP_UNMAPPED    = 2'd1;
   localparam logic [1:0] RSP_GLYPH_RANGE = 2'd2;
   localparam logic [1:0] RSP_OFF_BUFFER  = 2'd3;

   // csr register indexes
   localparam logic [1:0] CSR_GLYPH_ROWS    = 2'd0;
   localparam logic [1:0] CSR_BUFFER_WIDTH  = 2'd1;
   localparam logic [1:0] CSR_BUFFER_HEIGHT = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WRAP,
      ST_CHECK,
      ST_EMIT0,
      ST_EMIT1
   } psfgr_state_type;

   typedef struct packed {
      logic [5:0]            glyph_rows;
      logic [COORD_BITS-1:0] buffer_width;
      logic [COORD_BITS-1:0] buffer_height;
   } psfgr_cfg_type;

   typedef struct packed {
      logic       clear_wr;
      logic       table_wr;
      logic       glyph_wr;
      logic       draw_start;
      logic       wrap;
      logic       begin_rows;
      logic       emit_status;
      logic [1:0] status_code;
      logic       emit_half0;
      logic       emit_half1;
      logic       last;
   } psfgr_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic map_hit;
      logic glyph_oor;
      logic off_buffer;
      logic half0_last;
      logic row_last;
   } psfgr_stat_type;

   // each glyph bit becomes two adjacent pixels, msb leftmost
   function automatic logic [15:0] double_bits(input logic [7:0] bits);
      logic [15:0] res;
      res = '0;
      for (int c = 0; c < 8; c++) begin
         res[2*c]   = bits[c];
         res[2*c+1] = bits[c];
      end
      return res;
   endfunction

endpackage

FILE: hdl/psf1_glyph_renderer_top.sv
// psf1_glyph_renderer_top: psf1 character generator with double-scale output
// depends on psfgr_pkg, psfgr_ctrl and psfgr_dpath
//
// Command-style block: an item is taken when start is high and busy is low;
// every result beat is shown for exactly one cycle on the rsp_ ports with
// rsp_valid high, and the receiver cannot stall it. After reset the block
// sweeps the 65536-entry code map, one entry per cycle, and holds busy high
// until the sweep ends; csr writes are taken during the sweep. Table words
// and glyph row loads finish in the accept cycle and leave busy low, so one
// can follow every cycle. A draw item reads the code map at accept, then holds
// busy through the wrap and check states and an emit pair per emitted glyph
// row (the glyph store has a single read port, read once per glyph row, and
// the row is sent twice for double height). The first result beat is registered
// from the check state for status-only draws, else from the first emit state.
// Columns past the right edge come out with clear enable and pixel bits, and
// emission stops at the first destination row below the buffer.
module psf1_glyph_renderer_top (
   input  logic               clock,
   input  logic               reset,
   // item channel
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_op,
   input  logic [15:0]        req_code,
   input  logic [8:0]         req_glyph_index,
   input  logic [4:0]         req_glyph_row,
   input  logic [7:0]         req_row_bits,
   input  logic signed [12:0] req_pos_x,
   input  logic signed [12:0] req_pos_y,
   // result channel
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic [11:0]        rsp_dest_row,
   output logic [11:0]        rsp_dest_col,
   output logic [15:0]        rsp_pixels,
   output logic [15:0]        rsp_enables,
   output logic               rsp_last,
   // csr write channel
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [11:0]        csr_data
);
   import psfgr_pkg::*;

   psfgr_cfg_type  cfg_ff;
   psfgr_cmd_type  cmd;
   psfgr_stat_type stat;

   // config is to be written only while idle; the block itself does not enforce this rule, so always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.glyph_rows    <= 6'd16;
         cfg_ff.buffer_width  <= 12'd400;
         cfg_ff.buffer_height <= 12'd240;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_GLYPH_ROWS:    cfg_ff.glyph_rows    <= csr_data[5:0];
            CSR_BUFFER_WIDTH:  cfg_ff.buffer_width  <= csr_data;
            CSR_BUFFER_HEIGHT: cfg_ff.buffer_height <= csr_data;
            default:           cfg_ff               <= cfg_ff;
         endcase
      end
   end

   psfgr_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .op    (req_op),
      .stat  (stat),
      .busy  (busy),
      .cmd   (cmd)
   );

   psfgr_dpath u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .cmd          (cmd),
      .code         (req_code),
      .glyph_index  (req_glyph_index),
      .glyph_row    (req_glyph_row),
      .row_bits     (req_row_bits),
      .pos_x        (req_pos_x),
      .pos_y        (req_pos_y),
      .stat         (stat),
      .rsp_valid    (rsp_valid),
      .rsp_status   (rsp_status),
      .rsp_dest_row (rsp_dest_row),
      .rsp_dest_col (rsp_dest_col),
      .rsp_pixels   (rsp_pixels),
      .rsp_enables  (rsp_enables),
      .rsp_last     (rsp_last)
   );

   // at most one datapath action per cycle
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clear_wr, cmd.table_wr, cmd.glyph_wr, cmd.draw_start, cmd.wrap,
                cmd.begin_rows, cmd.emit_status, cmd.emit_half0, cmd.emit_half1}))
      else $error("more than one datapath command in a cycle");

   // a draw accept is followed by the wrap step
   a_draw_wrap: assert property (@(posedge clock) disable iff (reset)
      cmd.draw_start |=> cmd.wrap)
      else $error("draw accept not followed by wrap");

   // status beats end their item
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != RSP_PIXEL |-> rsp_last)
      else $error("status beat without last");

   // the first doubled pixel always lies inside the buffer
   a_first_enabled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == RSP_PIXEL |-> rsp_enables[15])
      else $error("pixel beat with first column masked");

endmodule

FILE: hdl/psfgr_ctrl.sv
// psfgr_ctrl: sequencer for map clearing, item decode and draw row emission
// depends on psfgr_pkg; drives psfgr_dpath through command and status structs
module psfgr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [1:0]              op,
   input  psfgr_pkg::psfgr_stat_type stat,
   output logic                    busy,
   output psfgr_pkg::psfgr_cmd_type  cmd
);
   import psfgr_pkg::*;

   psfgr_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (stat.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start && op == OP_DRAW) state_in = ST_WRAP;
         end
         ST_WRAP: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (!stat.map_hit || stat.glyph_oor || stat.off_buffer) state_in = ST_IDLE;
            else state_in = ST_EMIT0;
         end
         ST_EMIT0: begin
            state_in = stat.half0_last ? ST_IDLE : ST_EMIT1;
         end
         ST_EMIT1: begin
            state_in = stat.row_last ? ST_IDLE : ST_EMIT0;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
         end
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               unique case (op)
                  OP_TABLE: cmd.table_wr   = 1'b1;
                  OP_LOAD:  cmd.glyph_wr   = 1'b1;
                  OP_DRAW:  cmd.draw_start = 1'b1;
                  default:  cmd.table_wr   = 1'b0;
               endcase
            end
         end
         ST_WRAP: begin
            cmd.wrap = 1'b1;
         end
         ST_CHECK: begin
            if (!stat.map_hit) begin
               cmd.emit_status = 1'b1;
               cmd.status_code = RSP_UNMAPPED;
            end else if (stat.glyph_oor) begin
               cmd.emit_status = 1'b1;
               cmd.status_code = RSP_GLYPH_RANGE;
            end else if (stat.off_buffer) begin
               cmd.emit_status = 1'b1;
               cmd.status_code = RSP_OFF_BUFFER;
            end else begin
               cmd.begin_rows = 1'b1;
            end
            cmd.last = cmd.emit_status;
         end
         ST_EMIT0: begin
            cmd.emit_half0 = 1'b1;
            cmd.last       = stat.half0_last;
         end
         ST_EMIT1: begin
            cmd.emit_half1 = 1'b1;
            cmd.last       = stat.row_last;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

FILE: hdl/psfgr_dpath.sv
// psfgr_dpath: code map and glyph store memories, position wrap, row registers
// depends on psfgr_pkg; sequenced by psfgr_ctrl
module psfgr_dpath (
   input  logic                        clock,
   input  logic                        reset,
   input  psfgr_pkg::psfgr_cfg_type      cfg,
   input  psfgr_pkg::psfgr_cmd_type      cmd,
   input  logic [15:0]                 code,
   input  logic [8:0]                  glyph_index,
   input  logic [4:0]                  glyph_row,
   input  logic [7:0]                  row_bits,
   input  logic signed [12:0]          pos_x,
   input  logic signed [12:0]          pos_y,
   output psfgr_pkg::psfgr_stat_type     stat,
   output logic                        rsp_valid,
   output logic [1:0]                  rsp_status,
   output logic [11:0]                 rsp_dest_row,
   output logic [11:0]                 rsp_dest_col,
   output logic [15:0]                 rsp_pixels,
   output logic [15:0]                 rsp_enables,
   output logic                        rsp_last
);
   import psfgr_pkg::*;

   // code map: valid bit plus saturated glyph number
   logic [10:0]          map_mem [MAP_DEPTH];
   logic [10:0]          map_rd_ff;
   logic [CODE_BITS-1:0] clear_cnt_ff;
   logic [CNT_BITS-1:0]  tbl_cnt_ff;

   logic [7:0]            glyph_mem [STORE_DEPTH];
   logic [7:0]            glyph_rd_ff;
   logic                  glyph_rd_en;
   logic [STORE_BITS-1:0] glyph_rd_addr;
   logic                  load_ok;

   logic signed [12:0] px_ff, py_ff;
   logic signed [13:0] xw_ff, yw_ff;
   logic [ROW_BITS-1:0] rows_m1_ff, rows_m1_in;
   logic [ROW_BITS-1:0] sy_ff;
   logic [12:0]         dy_ff;
   logic [11:0]         dx_ff;
   logic [15:0]         en_ff, en_in;
   logic [15:0]         pix_ff, pix_now;
   logic [12:0]         en_span;

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_cnt_ff <= '0;
         tbl_cnt_ff   <= '0;
      end else begin
         if (cmd.clear_wr) clear_cnt_ff <= clear_cnt_ff + 1'b1;
         if (cmd.table_wr && code == TABLE_DELIM && tbl_cnt_ff <= GLYPH_LIMIT[CNT_BITS-1:0])
            tbl_cnt_ff <= tbl_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_wr) begin
         map_mem[clear_cnt_ff] <= '0;
      end else if (cmd.table_wr && code != TABLE_DELIM) begin
         map_mem[code[CODE_BITS-1:0]] <= {1'b1, 10'(tbl_cnt_ff)};
      end
      if (cmd.draw_start) map_rd_ff <= map_mem[code[CODE_BITS-1:0]];
   end

   assign load_ok = ({1'b0, glyph_index} < 10'(GLYPH_COUNT)) &&
                    ({1'b0, glyph_row} < 6'(MAX_GLYPH_ROWS));

   always_comb begin
      glyph_rd_en   = cmd.begin_rows || cmd.emit_half0;
      glyph_rd_addr = {map_rd_ff[GLYPH_BITS-1:0],
                       (cmd.emit_half0 ? ROW_BITS'(sy_ff + 1'b1) : ROW_BITS'(0))};
   end

   always_ff @(posedge clock) begin
      if (cmd.glyph_wr && load_ok)
         glyph_mem[{glyph_index[GLYPH_BITS-1:0], glyph_row[ROW_BITS-1:0]}] <= row_bits;
      if (glyph_rd_en) glyph_rd_ff <= glyph_mem[glyph_rd_addr];
   end

   // rows to draw, clamped to one..max
   always_comb begin
      if (cfg.glyph_rows == 6'd0) rows_m1_in = '0;
      else if (cfg.glyph_rows > 6'(MAX_GLYPH_ROWS)) rows_m1_in = ROW_BITS'(MAX_GLYPH_ROWS - 1);
      else rows_m1_in = ROW_BITS'(cfg.glyph_rows - 6'd1);
   end

   // pixel k of the run is inside when k < width - 2x
   always_comb begin
      en_span = {1'b0, cfg.buffer_width} - {1'b0, xw_ff[10:0], 1'b0};
      for (int k = 0; k < 16; k++) en_in[15-k] = (13'(k) < en_span);
   end

   assign pix_now = double_bits(glyph_rd_ff) & en_ff;

   always_ff @(posedge clock) begin
      if (cmd.draw_start) begin
         px_ff <= pos_x;
         py_ff <= pos_y;
      end
      if (cmd.wrap) begin
         xw_ff      <= px_ff[12] ? ({px_ff[12], px_ff} + $signed({2'b00, cfg.buffer_width}))
                                 : {px_ff[12], px_ff};
         yw_ff      <= py_ff[12] ? ({py_ff[12], py_ff} + $signed({2'b00, cfg.buffer_height}))
                                 : {py_ff[12], py_ff};
         rows_m1_ff <= rows_m1_in;
      end
      if (cmd.begin_rows) begin
         sy_ff <= '0;
         dy_ff <= {yw_ff[11:0], 1'b0};
         dx_ff <= {xw_ff[10:0], 1'b0};
         en_ff <= en_in;
      end
      if (cmd.emit_half0) pix_ff <= pix_now;
      if (cmd.emit_half1) begin
         sy_ff <= sy_ff + 1'b1;
         dy_ff <= dy_ff + 13'd2;
      end
   end

   always_comb begin
      stat.clear_done = (clear_cnt_ff == '1);
      stat.map_hit    = map_rd_ff[10];
      stat.glyph_oor  = (map_rd_ff[9:0] > GLYPH_LIMIT) || (map_rd_ff[9:0] >= 10'(GLYPH_COUNT));
      stat.off_buffer = xw_ff[13] || yw_ff[13] ||
                        ({xw_ff[12:0], 1'b0} >= {2'b00, cfg.buffer_width}) ||
                        ({yw_ff[12:0], 1'b0} >= {2'b00, cfg.buffer_height});
      stat.half0_last = ({1'b0, dy_ff} + 14'd1) >= {2'b00, cfg.buffer_height};
      stat.row_last   = (sy_ff == rows_m1_ff) ||
                        (({1'b0, dy_ff} + 14'd2) >= {2'b00, cfg.buffer_height});
   end

   // result register: at most one beat per cycle, receiver never stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= cmd.emit_status || cmd.emit_half0 || cmd.emit_half1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_status) begin
         rsp_status   <= cmd.status_code;
         rsp_dest_row <= '0;
         rsp_dest_col <= '0;
         rsp_pixels   <= '0;
         rsp_enables  <= '0;
         rsp_last     <= 1'b1;
      end else if (cmd.emit_half0 || cmd.emit_half1) begin
         rsp_status   <= RSP_PIXEL;
         rsp_dest_row <= cmd.emit_half1 ? 12'(dy_ff + 13'd1) : dy_ff[11:0];
         rsp_dest_col <= dx_ff;
         rsp_pixels   <= cmd.emit_half1 ? pix_ff : pix_now;
         rsp_enables  <= en_ff;
         rsp_last     <= cmd.last;
      end
   end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for psf1_glyph_renderer_top, double-scale glyph drawing
// depends on psfgr_pkg and the psf1_glyph_renderer_top rtl; predicts every result beat
module tb_top;
   import psfgr_pkg::*;

   // op code the block ignores
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // the code map sweep after reset covers MAP_DEPTH entries while no items are taken
   localparam int STALL_LIMIT   = 3 * MAP_DEPTH;
   // margin for the longest draw, 32 glyph rows sent twice each, to finish
   localparam int SETTLE_CYCLES = 80;
   localparam int RANDOM_ITEMS  = 380;
   localparam int PHASES        = 6;

   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] code;
      logic [8:0]  glyph_index;
      logic [4:0]  glyph_row;
      logic [7:0]  row_bits;
      logic [12:0] pos_x;
      logic [12:0] pos_y;
   } glyph_cmd_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [11:0] dest_row;
      logic [11:0] dest_col;
      logic [15:0] pixels;
      logic [15:0] enables;
      logic        last;
   } pixel_run_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [1:0]         req_op = '0;
   logic [15:0]        req_code = '0;
   logic [8:0]         req_glyph_index = '0;
   logic [4:0]         req_glyph_row = '0;
   logic [7:0]         req_row_bits = '0;
   logic signed [12:0] req_pos_x = '0;
   logic signed [12:0] req_pos_y = '0;
   logic               rsp_valid;
   logic [1:0]         rsp_status;
   logic [11:0]        rsp_dest_row;
   logic [11:0]        rsp_dest_col;
   logic [15:0]        rsp_pixels;
   logic [15:0]        rsp_enables;
   logic               rsp_last;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [1:0]         csr_index = '0;
   logic [11:0]        csr_data = '0;

   psf1_glyph_renderer_top DUT (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // font state as the block holds it, updated on accepted beats
   bit [9:0]   font_map [bit [15:0]];   // absent entry means code unmapped
   bit [7:0]   font_rows [int];         // key glyph * MAX_GLYPH_ROWS + row
   int         font_counter = 0;
   int         cfg_rows = 16;
   int         cfg_width = 400;
   int         cfg_height = 240;
   pixel_run_type run_queue [$];        // pixel rows and status beats still owed

   // font state as it will be once every queued item is taken
   bit [31:0]  plan_loaded [GLYPH_COUNT];
   bit [9:0]   plan_map [bit [15:0]];
   bit [15:0]  plan_codes [$];
   int         plan_counter = 0;

   glyph_cmd_type cmd_queue [$];
   int         cmd_total = 0;
   int         issued_count = 0;
   int         accepted_count = 0;
   int         idle_left = 0;
   bit         calm = 1'b0;
   int         mismatches = 0;
   int         quiet_cycles = 0;

   // rows actually drawn: zero draws one, large values clip
   function automatic int rows_drawn();
      if (cfg_rows == 0) return 1;
      if (cfg_rows > MAX_GLYPH_ROWS) return MAX_GLYPH_ROWS;
      return cfg_rows;
   endfunction

   // work out the beats one accepted item owes
   function automatic void predict_runs(input glyph_cmd_type c);
      int x, y, w, h, stop_row, key;
      bit [9:0] g;
      logic [15:0] en, pix;
      logic [7:0] bits;
      pixel_run_type r;
      r = '0;
      r.last = 1'b1;
      w = cfg_width;
      h = cfg_height;
      case (c.op)
         OP_TABLE: begin
            if (c.code == TABLE_DELIM) begin
               if (font_counter <= GLYPH_LIMIT) font_counter++;
            end else begin
               font_map[c.code] = 10'(font_counter);
            end
         end
         OP_LOAD: begin
            font_rows[c.glyph_index * MAX_GLYPH_ROWS + c.glyph_row] = c.row_bits;
         end
         OP_DRAW: begin
            x = int'($signed(c.pos_x));
            y = int'($signed(c.pos_y));
            // negative start counts back from the far edge
            if (y < 0) y += h;
            if (x < 0) x += w;
            if (!font_map.exists(c.code)) r.status = RSP_UNMAPPED;
            else if (font_map[c.code] > GLYPH_LIMIT) r.status = RSP_GLYPH_RANGE;
            else if (y < 0 || y >= h || x < 0 || x >= w || 2 * x >= w || 2 * y >= h)
               r.status = RSP_OFF_BUFFER;
            if (r.status != RSP_PIXEL) begin
               run_queue.push_back(r);
            end else begin
               g = font_map[c.code];
               en = '0;
               for (int k = 0; k < 16; k++)
                  if (2 * x + k < w) en[15 - k] = 1'b1;
               // rows stop at the bottom edge of the buffer
               stop_row = 2 * (y + rows_drawn());
               if (stop_row > h) stop_row = h;
               for (int dr = 2 * y; dr < stop_row; dr++) begin
                  key = g * MAX_GLYPH_ROWS + dr / 2 - y;
                  bits = font_rows.exists(key) ? font_rows[key] : 8'h00;
                  pix = '0;
                  for (int b = 0; b < 8; b++)
                     if (bits[7 - b]) pix[15 - 2 * b -: 2] = 2'b11;
                  r.status   = RSP_PIXEL;
                  r.dest_row = 12'(dr);
                  r.dest_col = 12'(2 * x);
                  r.pixels   = pix & en;
                  r.enables  = en;
                  r.last     = (dr == stop_row - 1);
                  run_queue.push_back(r);
               end
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void report_run(input string what, input pixel_run_type want,
                                      input pixel_run_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%0t %s: expected st=%0d row=%0d col=%0d pix=%h en=%h last=%0b",
                  $time, what, want.status, want.dest_row, want.dest_col, want.pixels,
                  want.enables, want.last);
         $display("%0t %s: got      st=%0d row=%0d col=%0d pix=%h en=%h last=%0b",
                  $time, what, got.status, got.dest_row, got.dest_col, got.pixels,
                  got.enables, got.last);
      end
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   // queue one item and keep the planned font state in step with it
   function automatic void push_cmd(input glyph_cmd_type c);
      case (c.op)
         OP_TABLE: begin
            if (c.code == TABLE_DELIM) begin
               if (plan_counter <= GLYPH_LIMIT) plan_counter++;
            end else begin
               plan_map[c.code] = 10'(plan_counter);
               plan_codes.push_back(c.code);
            end
         end
         OP_LOAD: plan_loaded[c.glyph_index][c.glyph_row] = 1'b1;
         default: ;
      endcase
      if (c.op != OP_UNUSED) cmd_total++;
      cmd_queue.push_back(c);
   endfunction

   // fields the op does not use carry random noise
   function automatic glyph_cmd_type random_cmd(input logic [1:0] op);
      glyph_cmd_type c;
      c.op          = op;
      c.code        = 16'($urandom);
      c.glyph_index = 9'($urandom);
      c.glyph_row   = 5'($urandom);
      c.row_bits    = 8'($urandom);
      c.pos_x       = 13'($urandom);
      c.pos_y       = 13'($urandom);
      return c;
   endfunction

   function automatic glyph_cmd_type table_cmd(input bit [15:0] word);
      glyph_cmd_type c;
      c = random_cmd(OP_TABLE);
      c.code = word;
      return c;
   endfunction

   function automatic glyph_cmd_type load_cmd(input bit [8:0] g, input bit [4:0] row,
                                              input bit [7:0] bits);
      glyph_cmd_type c;
      c = random_cmd(OP_LOAD);
      c.glyph_index = g;
      c.glyph_row   = row;
      c.row_bits    = bits;
      return c;
   endfunction

   function automatic bit [7:0] glyph_pattern();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hff;
         default: return 8'($urandom);
      endcase
   endfunction

   // start coordinate: mostly on the buffer, some near the edges, some wrapped or wild
   function automatic logic [12:0] pick_coord(input int span);
      int v, mid;
      mid = (span - 1) / 2;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: v = int'($urandom_range(0, mid));
         5, 6: v = mid + 2 - int'($urandom_range(0, 9));
         7: v = int'($urandom_range(0, mid)) - span;
         8: v = -int'($urandom_range(1, span));
         default: v = int'($urandom_range(0, 8191)) - 4096;
      endcase
      return 13'(v);
   endfunction

   // every glyph row a draw can touch must be loaded first
   function automatic void draw_at(input bit [15:0] code, input logic [12:0] x,
                                   input logic [12:0] y);
      int g;
      glyph_cmd_type c;
      if (plan_map.exists(code)) begin
         g = plan_map[code];
         if (g < GLYPH_COUNT)
            for (int r = 0; r < rows_drawn(); r++)
               if (!plan_loaded[g][r]) push_cmd(load_cmd(9'(g), 5'(r), glyph_pattern()));
      end
      c = random_cmd(OP_DRAW);
      c.code  = code;
      c.pos_x = x;
      c.pos_y = y;
      push_cmd(c);
   endfunction

   function automatic void draw_item(input bit [15:0] code);
      draw_at(code, pick_coord(cfg_width), pick_coord(cfg_height));
   endfunction

   function automatic bit [15:0] pick_known_code();
      if (plan_codes.size() == 0) return 16'($urandom);
      return plan_codes[$urandom_range(0, plan_codes.size() - 1)];
   endfunction

   // one glyph of a font: its unicode words, its bitmap, the delimiter, then a few draws
   function automatic void font_sequence();
      int g;
      bit [15:0] cw;
      bit [15:0] fresh [$];
      g = plan_counter;
      repeat ($urandom_range(1, 3)) begin
         cw = 16'($urandom_range(0, 16'hfffe));
         fresh.push_back(cw);
         push_cmd(table_cmd(cw));
      end
      if (g < GLYPH_COUNT)
         for (int r = 0; r < rows_drawn(); r++)
            push_cmd(load_cmd(9'(g), 5'(r), glyph_pattern()));
      push_cmd(table_cmd(TABLE_DELIM));
      repeat ($urandom_range(1, 3)) begin
         if ($urandom_range(0, 2) != 0) draw_item(fresh[$urandom_range(0, fresh.size() - 1)]);
         else draw_item(pick_known_code());
      end
   endfunction

   // stray items: ignored ops, scattered loads, loose table words, odd codes
   function automatic void noise_item();
      case ($urandom_range(0, 4))
         0: push_cmd(random_cmd(OP_UNUSED));
         1: push_cmd(load_cmd(9'($urandom), 5'($urandom), 8'($urandom)));
         2: push_cmd(table_cmd(($urandom_range(0, 3) == 0) ? TABLE_DELIM : 16'($urandom)));
         3: draw_item(16'($urandom));
         default: draw_item(pick_known_code());
      endcase
   endfunction

   function automatic void directed_items();
      // code map is all invalid after reset, and the delimiter code never maps
      draw_at(16'h0041, 13'd0, 13'd0);
      draw_at(TABLE_DELIM, 13'd0, 13'd0);
      push_cmd(table_cmd(16'h0000));
      push_cmd(table_cmd(16'hfffe));
      // far corner of the glyph store
      push_cmd(load_cmd(9'd511, 5'd31, 8'hff));
      push_cmd(load_cmd(9'd0, 5'd0, 8'hff));
      push_cmd(load_cmd(9'd0, 5'd1, 8'h00));
      push_cmd(load_cmd(9'd0, 5'd2, 8'h80));
      push_cmd(load_cmd(9'd0, 5'd3, 8'h01));
      push_cmd(load_cmd(9'd0, 5'd4, 8'h5a));
      draw_at(16'h0000, 13'd0, 13'd0);
      // last on-buffer start: clipped on the right and cut off at the bottom
      draw_at(16'hfffe, 13'd199, 13'd119);
      // doubled start off the buffer on either axis
      draw_at(16'h0000, 13'd200, 13'd0);
      draw_at(16'h0000, 13'd0, 13'd120);
      // negative starts wrap by the buffer size
      draw_at(16'h0000, 13'h1fff, 13'd0);
      draw_at(16'h0000, 13'(-400), 13'(-240));
      draw_at(16'h0000, 13'd4095, 13'h1000);
      push_cmd(random_cmd(OP_UNUSED));
      // delimiter moves the counter on but leaves old entries alone
      push_cmd(table_cmd(TABLE_DELIM));
      draw_at(16'hfffe, 13'd3, 13'd5);
   endfunction

   // ---------------------------------------------------------------- driver

   // one item per beat; a random gap may follow a beat unless the run is calm
   always @(negedge clock) begin : drive_items
      glyph_cmd_type nxt;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || accepted_count == issued_count) begin
         if (idle_left > 0) begin
            idle_left--;
            start <= 1'b0;
         end else if (cmd_queue.size() != 0) begin
            nxt = cmd_queue.pop_front();
            issued_count++;
            start           <= 1'b1;
            req_op          <= nxt.op;
            req_code        <= nxt.code;
            req_glyph_index <= nxt.glyph_index;
            req_glyph_row   <= nxt.glyph_row;
            req_row_bits    <= nxt.row_bits;
            req_pos_x       <= nxt.pos_x;
            req_pos_y       <= nxt.pos_y;
            if (!calm && $urandom_range(0, 7) == 0) idle_left = $urandom_range(1, 18);
         end else begin
            start <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   // checks result beats, predicts on accepted items, tracks csr writes, watchdog
   always @(posedge clock) begin : watch_ports
      pixel_run_type got, want;
      glyph_cmd_type seen;
      if (!reset) begin
         if (rsp_valid) begin
            got = {rsp_status, rsp_dest_row, rsp_dest_col, rsp_pixels, rsp_enables, rsp_last};
            if (run_queue.size() == 0) begin
               report_run("beat with nothing owed", '0, got);
            end else begin
               want = run_queue.pop_front();
               if (got.status !== want.status || got.dest_row !== want.dest_row ||
                   got.dest_col !== want.dest_col || got.pixels !== want.pixels ||
                   got.enables !== want.enables || got.last !== want.last)
                  report_run("beat mismatch", want, got);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_GLYPH_ROWS:    cfg_rows = int'(csr_data[5:0]);
               CSR_BUFFER_WIDTH:  cfg_width = int'(csr_data);
               CSR_BUFFER_HEIGHT: cfg_height = int'(csr_data);
               default: ;
            endcase
         end
         if (start && !busy) begin
            seen = {req_op, req_code, req_glyph_index, req_glyph_row, req_row_bits,
                    req_pos_x, req_pos_y};
            predict_runs(seen);
            accepted_count++;
         end
         // nothing moving on any channel for too long
         if (rsp_valid || (csr_valid && csr_ready) || (start && !busy)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
               $display("Mismatches found");
               $finish;
            end
         end
      end
   end

   // ---------------------------------------------------------------- sequencing

   task automatic write_csr(input logic [1:0] idx, input logic [11:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_geometry(input logic [11:0] rows, input logic [11:0] width,
                               input logic [11:0] height);
      write_csr(CSR_GLYPH_ROWS, rows);
      write_csr(CSR_BUFFER_WIDTH, width);
      write_csr(CSR_BUFFER_HEIGHT, height);
   endtask

   // all items taken and all beats in, then let trailing work finish
   task automatic drain();
      while (cmd_queue.size() != 0 || accepted_count != issued_count || run_queue.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin : stimulus
      int target;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // csr writes go through while the block sweeps its code map
      set_geometry(12'd5, 12'd400, 12'd240);
      directed_items();
      drain();

      for (int phase = 1; phase <= PHASES; phase++) begin
         case (phase)
            1: set_geometry(12'd0, 12'd1, 12'd1);            // zero rows, single pixel buffer
            2: set_geometry(12'd32, 12'd4095, 12'd4095);     // largest glyph and buffer
            3: set_geometry(12'd63, 12'd37, 12'd70);         // row count clipped to the store
            4: set_geometry(12'd8, 12'($urandom_range(1, 4095)),
                            12'($urandom_range(1, 4095)));
            5: set_geometry(12'd1, 12'd2, 12'd3);
            default: set_geometry(12'($urandom_range(1, 32)), 12'd400, 12'd240);
         endcase
         // last stretch runs with no gaps
         calm = (phase == PHASES);
         target = cmd_total + RANDOM_ITEMS / PHASES;
         while (cmd_total < target) begin
            if ($urandom_range(0, 4) != 0) font_sequence();
            else noise_item();
         end
         drain();
      end

      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

FILE: sim.f
hdl/psfgr_pkg.sv
hdl/psfgr_ctrl.sv
hdl/psfgr_dpath.sv
hdl/psf1_glyph_renderer_top.sv
tb/tb_top.sv
